[hdl/iis_pkg.sv]
package iis_pkg;

    // Fixed field widths
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 28;
    localparam int RUN_W  = 18;
    localparam int CFG_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

[hdl/integral_image_stream_unit.sv]
// Streaming integral image (summed-area table) for one 8-bit channel. Pixels
// enter in raster order and each beat on the result side carries the sum of all
// pixels above and to the left of it, itself included, with frame_last set on
// the final pixel of the frame. The block takes one pixel per clock unless m_ready
// holds the output; each accepted pixel passes the read stage and then the output
// register. The rate is set by the line store: one read and one write port, one
// read and one write-back per pixel. When the image is one pixel wide, the pixel
// just written is forwarded to the next one. Line-store contents need no
// clearing; the first row never uses what it reads. Width and height are written
// through the APB port at byte addresses 0 and 4 and must only be changed between
// frames; 0 acts as 1 and values above MAX_WIDTH or MAX_HEIGHT act as that maximum.
module integral_image_stream_unit #(
    parameter int MAX_WIDTH  = iis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iis_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = iis_pkg::PIXEL_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iis_pkg::ADDR_W-1:0]  paddr,
    input  logic [iis_pkg::DATA_W-1:0]  pwdata,
    output logic [iis_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Pixel input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [iis_pkg::PIX_W-1:0]   s_pixel_value,
    // Result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [iis_pkg::SUM_W-1:0]   m_area_sum,
    output logic                        m_frame_last
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [iis_pkg::PIX_W-1:0] PIX_MASK =
        (PIXEL_BITS >= iis_pkg::PIX_W) ? {iis_pkg::PIX_W{1'b1}}
                                       : iis_pkg::PIX_W'((1 << PIXEL_BITS) - 1);

    // Configuration registers
    logic [iis_pkg::CFG_W-1:0] width_reg;
    logic [iis_pkg::CFG_W-1:0] height_reg;
    logic                      cfg_wr;

    // Stream state
    logic                      active_reg;
    logic [CW-1:0]             column_count_reg, column_count_next;
    logic [RW-1:0]             row_count_reg, row_count_next;
    logic [iis_pkg::RUN_W-1:0] run_sum_reg, run_sum_next;

    // Read stage
    logic                      s1_valid_reg;
    logic [CW-1:0]             s1_col_reg;
    logic [iis_pkg::RUN_W-1:0] s1_run_reg;
    logic                      s1_above_reg;
    logic                      s1_last_reg;
    logic                      s1_fwd_reg;
    logic [iis_pkg::SUM_W-1:0] rdata_reg;

    // Output register
    logic                      m_valid_reg;
    logic [iis_pkg::SUM_W-1:0] m_area_sum_reg;
    logic                      m_frame_last_reg;

    // Line store
    logic [iis_pkg::SUM_W-1:0] row_store [MAX_WIDTH];

    logic                      in_acc;
    logic                      s1_adv;
    logic [CW-1:0]             w_last;
    logic [RW-1:0]             h_last;
    logic                      row_end;
    logic                      col_end;
    logic [iis_pkg::PIX_W-1:0] pix;
    logic [iis_pkg::SUM_W-1:0] above;
    logic [iis_pkg::SUM_W-1:0] area;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= iis_pkg::WIDTH_RST;
            height_reg <= iis_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            case (iis_pkg::reg_idx_t'(paddr[2]))
                iis_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[iis_pkg::CFG_W-1:0];
                iis_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[iis_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (iis_pkg::reg_idx_t'(paddr[2]))
            iis_pkg::REG_IMAGE_WIDTH:
                prdata = iis_pkg::DATA_W'(width_reg);
            iis_pkg::REG_IMAGE_HEIGHT:
                prdata = iis_pkg::DATA_W'(height_reg);
            default:
                prdata = '0;
        endcase
    end

    // Clamp sizes to last column and last row
    always_comb begin
        if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(width_reg - 1'b1);

        if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(height_reg - 1'b1);
    end

    // Handshake
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = active_reg && (!s1_valid_reg || s1_adv);
    assign in_acc  = s_valid && s_ready;

    // Position and running row sum for the incoming beat
    assign pix     = s_pixel_value & PIX_MASK;
    assign row_end = column_count_reg >= w_last;
    assign col_end = row_count_reg >= h_last;

    always_comb begin
        run_sum_next = ((column_count_reg == '0) ? '0 : run_sum_reg)
                     + iis_pkg::RUN_W'(pix);
        if (row_end) begin
            column_count_next = '0;
            row_count_next    = col_end ? '0 : row_count_reg + 1'b1;
        end else begin
            column_count_next = column_count_reg + 1'b1;
            row_count_next    = row_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            run_sum_reg      <= '0;
            s1_valid_reg     <= 1'b0;
        end else begin
            active_reg <= 1'b1;
            if (in_acc) begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                run_sum_reg      <= run_sum_next;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    // Read stage payload; forward when the entry is written in the same cycle
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_col_reg   <= column_count_reg;
            s1_run_reg   <= run_sum_next;
            s1_above_reg <= row_count_reg != '0;
            s1_last_reg  <= row_end && col_end;
            s1_fwd_reg   <= s1_adv && (s1_col_reg == column_count_reg);
        end
    end

    // Line store: read on accept, write back on advance
    always_ff @(posedge aclk) begin
        if (in_acc)
            rdata_reg <= row_store[column_count_reg];
        if (s1_adv)
            row_store[s1_col_reg] <= area;
    end

    // Add the row above
    assign above = s1_fwd_reg ? m_area_sum_reg : rdata_reg;
    assign area  = (s1_above_reg ? above : '0) + iis_pkg::SUM_W'(s1_run_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (s1_adv)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_area_sum_reg   <= area;
            m_frame_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_area_sum   = m_area_sum_reg;
    assign m_frame_last = m_frame_last_reg;

endmodule

[hdl/iis_checker.sv]
module iis_assert (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [iis_pkg::SUM_W-1:0]   m_area_sum,
    input logic                        m_frame_last
);

    // Config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_area_sum) && $stable(m_frame_last))
        else $error("stalled result changed");

    // A fresh result follows an accepted pixel
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without accepted pixel");

    // Input stalls only when the output is full and blocked
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without backpressure");

endmodule

bind integral_image_stream_unit iis_assert u_iis_assert (.*);
